>>> rtl/pcl_pkg.sv
// ----------------------------------------------------------------------------
// pcl_pkg
// Shared types and constants of the positional circular list: opcodes,
// status codes, controller states and the command and status bundles that
// join the controller and the datapath.
// ----------------------------------------------------------------------------
package pcl_pkg;

	// Field widths of one input transaction and one result transaction.
	localparam int OPCODE_W = 3;
	localparam int VALUE_W  = 32;
	localparam int POS_W    = 8;
	localparam int STATUS_W = 2;
	localparam int ELEM_W   = 32;
	localparam int COUNT_W  = 5;

	// Stream data widths, rounded up to whole bytes; the user field carries the status.
	localparam int S_TDATA_W = 48;
	localparam int M_TDATA_W = 40;
	localparam int M_TUSER_W = STATUS_W;

	localparam int DEF_CAPACITY   = 16;
	localparam int DEF_DATA_WIDTH = 32;

	typedef enum logic [OPCODE_W-1:0] {
		OP_INS_FRONT = 3'd0,
		OP_INS_BACK  = 3'd1,
		OP_DEL_FRONT = 3'd2,
		OP_DEL_BACK  = 3'd3,
		OP_INS_AT    = 3'd4,
		OP_DEL_AT    = 3'd5,
		OP_DUMP      = 3'd6
	} opcode_t;

	typedef enum logic [STATUS_W-1:0] {
		STS_OK     = 2'd0,
		STS_EMPTY  = 2'd1,
		STS_FULL   = 2'd2,
		STS_BADPOS = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECIDE,
		S_SHIFT,
		S_FIN,
		S_EMIT,
		S_DUMP_RD,
		S_DUMP_OUT
	} state_t;

	typedef enum logic [2:0] {
		IDX_HOLD,
		IDX_LOAD_COUNT,
		IDX_LOAD_POSM1,
		IDX_ZERO,
		IDX_INC,
		IDX_DEC
	} idx_op_t;

	typedef enum logic [1:0] {
		RD_IDX,
		RD_IDX_M1,
		RD_IDX_P1
	} rd_sel_t;

	typedef enum logic [1:0] {
		WR_HEAD_M1,
		WR_COUNT,
		WR_IDX
	} wr_sel_t;

	typedef enum logic [1:0] {
		HEAD_HOLD,
		HEAD_DEC,
		HEAD_INC
	} head_op_t;

	typedef enum logic [1:0] {
		CNT_HOLD,
		CNT_INC,
		CNT_DEC
	} cnt_op_t;

	// Controller to datapath.
	typedef struct packed {
		logic     load;
		idx_op_t  idx_op;
		logic     rd_en;
		rd_sel_t  rd_sel;
		logic     mv;
		logic     wr_val;
		wr_sel_t  wr_sel;
		head_op_t head_op;
		cnt_op_t  cnt_op;
		logic     st_load;
		status_t  st;
		logic     emit_one;
		logic     emit_elem;
	} pcl_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		opcode_t op;
		logic    empty;
		logic    full;
		logic    pos_ok_ins;
		logic    pos_ok_del;
		logic    more;
		logic    pend;
		logic    out_free;
		logic    dump_last;
	} pcl_stat_t;

endpackage

>>> rtl/pcl_ctrl.sv
// ----------------------------------------------------------------------------
// pcl_ctrl
// Controller of the positional circular list. Decodes each operation,
// sequences the entry moves of positional insert and delete, and paces the
// dump against the result register.
// ----------------------------------------------------------------------------
module pcl_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  pcl_pkg::pcl_stat_t  stat,
	output pcl_pkg::pcl_cmd_t   cmd
);
	import pcl_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		s_tready     = 1'b0;
		cmd          = '0;
		cmd.idx_op   = IDX_HOLD;
		cmd.rd_sel   = RD_IDX;
		cmd.wr_sel   = WR_IDX;
		cmd.head_op  = HEAD_HOLD;
		cmd.cnt_op   = CNT_HOLD;
		cmd.st       = STS_OK;
		case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = S_DECIDE;
				end
			end
			S_DECIDE: begin
				cmd.st_load = 1'b1;
				cmd.st      = STS_OK;
				state_d     = S_EMIT;
				case (stat.op)
					OP_INS_FRONT: begin
						if (stat.full) begin
							cmd.st = STS_FULL;
						end else begin
							cmd.wr_val  = 1'b1;
							cmd.wr_sel  = WR_HEAD_M1;
							cmd.head_op = HEAD_DEC;
							cmd.cnt_op  = CNT_INC;
						end
					end
					OP_INS_BACK: begin
						if (stat.full) begin
							cmd.st = STS_FULL;
						end else begin
							cmd.wr_val = 1'b1;
							cmd.wr_sel = WR_COUNT;
							cmd.cnt_op = CNT_INC;
						end
					end
					OP_DEL_FRONT: begin
						if (stat.empty) begin
							cmd.st = STS_EMPTY;
						end else begin
							cmd.head_op = HEAD_INC;
							cmd.cnt_op  = CNT_DEC;
						end
					end
					OP_DEL_BACK: begin
						if (stat.empty) begin
							cmd.st = STS_EMPTY;
						end else begin
							cmd.cnt_op = CNT_DEC;
						end
					end
					OP_INS_AT: begin
						// The position is checked before fullness.
						if (!stat.pos_ok_ins) begin
							cmd.st = STS_BADPOS;
						end else if (stat.full) begin
							cmd.st = STS_FULL;
						end else begin
							cmd.idx_op = IDX_LOAD_COUNT;
							state_d    = S_SHIFT;
						end
					end
					OP_DEL_AT: begin
						if (stat.empty) begin
							cmd.st = STS_EMPTY;
						end else if (!stat.pos_ok_del) begin
							cmd.st = STS_BADPOS;
						end else begin
							cmd.idx_op = IDX_LOAD_POSM1;
							state_d    = S_SHIFT;
						end
					end
					OP_DUMP: begin
						if (stat.empty) begin
							cmd.st = STS_EMPTY;
						end else begin
							cmd.idx_op = IDX_ZERO;
							state_d    = S_DUMP_RD;
						end
					end
					default: begin
						cmd.st = STS_OK;
					end
				endcase
			end
			S_SHIFT: begin
				// One entry move issued per cycle; its write lands in the following cycle.
				if (stat.more) begin
					cmd.rd_en = 1'b1;
					cmd.mv    = 1'b1;
					if (stat.op == OP_INS_AT) begin
						cmd.rd_sel = RD_IDX_M1;
						cmd.idx_op = IDX_DEC;
					end else begin
						cmd.rd_sel = RD_IDX_P1;
						cmd.idx_op = IDX_INC;
					end
				end else begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (!stat.pend) begin
					if (stat.op == OP_INS_AT) begin
						cmd.wr_val = 1'b1;
						cmd.wr_sel = WR_IDX;
						cmd.cnt_op = CNT_INC;
					end else begin
						cmd.cnt_op = CNT_DEC;
					end
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				if (stat.out_free) begin
					cmd.emit_one = 1'b1;
					state_d      = S_IDLE;
				end
			end
			S_DUMP_RD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RD_IDX;
				state_d    = S_DUMP_OUT;
			end
			S_DUMP_OUT: begin
				if (stat.out_free) begin
					cmd.emit_elem = 1'b1;
					cmd.idx_op    = IDX_INC;
					if (stat.dump_last) begin
						state_d = S_IDLE;
					end else begin
						cmd.rd_en  = 1'b1;
						cmd.rd_sel = RD_IDX_P1;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	a_load_then_decide: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == S_DECIDE)
		else $error("accepted transaction was not followed by decode");

endmodule

>>> rtl/pcl_dp.sv
// ----------------------------------------------------------------------------
// pcl_dp
// Datapath of the positional circular list: the ring store with one write
// and one registered read port, head and count registers, the walk index,
// the entry move stage and the result register.
// ----------------------------------------------------------------------------
module pcl_dp #(
	parameter int CAPACITY   = pcl_pkg::DEF_CAPACITY,
	parameter int DATA_WIDTH = pcl_pkg::DEF_DATA_WIDTH
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic [pcl_pkg::OPCODE_W-1:0]         in_opcode,
	input  logic signed [pcl_pkg::VALUE_W-1:0]   in_value,
	input  logic [pcl_pkg::POS_W-1:0]            in_position,
	input  pcl_pkg::pcl_cmd_t                    cmd,
	output pcl_pkg::pcl_stat_t                   stat,
	input  logic                                 m_tready,
	output logic                                 m_tvalid,
	output pcl_pkg::status_t                     m_status,
	output logic signed [pcl_pkg::ELEM_W-1:0]    m_element,
	output logic [pcl_pkg::COUNT_W-1:0]          m_count,
	output logic                                 m_last
);
	import pcl_pkg::*;

	localparam int IW   = $clog2(CAPACITY);
	localparam int CW   = $clog2(CAPACITY + 1);
	localparam int CMPW = ((CW > POS_W) ? CW : POS_W) + 1;

	// Ring position of a logical index: one compare and subtract.
	function automatic logic [IW-1:0] slot_of(input logic [IW-1:0] h,
		input logic [CW-1:0] l);
		logic [CW:0] s;
		s = (CW+1)'(h) + (CW+1)'(l);
		if (s >= (CW+1)'(CAPACITY)) begin
			s = s - (CW+1)'(CAPACITY);
		end
		return s[IW-1:0];
	endfunction

	logic [DATA_WIDTH-1:0] mem [CAPACITY];
	logic [DATA_WIDTH-1:0] rdata_q;

	opcode_t               op_q;
	logic [DATA_WIDTH-1:0] val_q;
	logic [POS_W-1:0]      pos_q;
	status_t               st_q;
	logic [IW-1:0]         head_q;
	logic [CW-1:0]         count_q;
	logic [CW-1:0]         idx_q;

	logic                  wv_s1;
	logic [IW-1:0]         wa_s1;

	logic                  out_valid_q;
	status_t               out_status_q;
	logic [ELEM_W-1:0]     out_elem_q;
	logic [COUNT_W-1:0]    out_count_q;
	logic                  out_last_q;

	logic signed [63:0]           val_ext;
	logic signed [DATA_WIDTH-1:0] rd_signed;
	logic signed [63:0]           rd_ext;
	logic [IW-1:0]                head_dec;
	logic [IW-1:0]                head_inc;
	logic [CW-1:0]                idx_m1;
	logic [CW-1:0]                idx_p1;
	logic [IW-1:0]                raddr;
	logic [IW-1:0]                vaddr;
	logic [CMPW-1:0]              pos_w;
	logic [CMPW-1:0]              cnt_w;
	logic [CMPW-1:0]              idx_w;
	logic [CW+4:0]                cnt_wide;
	logic                         out_free;

	assign val_ext   = 64'(in_value);
	assign rd_signed = rdata_q;
	assign rd_ext    = 64'(rd_signed);
	assign head_dec  = (head_q == '0) ? IW'(CAPACITY - 1) : head_q - 1'b1;
	assign head_inc  = (head_q == IW'(CAPACITY - 1)) ? '0 : head_q + 1'b1;
	assign idx_m1    = idx_q - 1'b1;
	assign idx_p1    = idx_q + 1'b1;
	assign pos_w     = CMPW'(pos_q);
	assign cnt_w     = CMPW'(count_q);
	assign idx_w     = CMPW'(idx_q);
	assign cnt_wide  = (CW+5)'(count_q);
	assign out_free  = !out_valid_q || m_tready;

	always_comb begin
		case (cmd.rd_sel)
			RD_IDX_M1: raddr = slot_of(head_q, idx_m1);
			RD_IDX_P1: raddr = slot_of(head_q, idx_p1);
			default:   raddr = slot_of(head_q, idx_q);
		endcase
		case (cmd.wr_sel)
			WR_HEAD_M1: vaddr = head_dec;
			WR_COUNT:   vaddr = slot_of(head_q, count_q);
			default:    vaddr = slot_of(head_q, idx_q);
		endcase
	end

	always_comb begin
		stat            = '0;
		stat.op         = op_q;
		stat.empty      = (count_q == '0);
		stat.full       = (count_q == CW'(CAPACITY));
		stat.pos_ok_ins = (pos_q != '0) && (pos_w <= cnt_w + 1'b1);
		stat.pos_ok_del = (pos_q != '0) && (pos_w <= cnt_w);
		// Insert walks down to pos-1, delete walks up to count-1.
		stat.more       = (op_q == OP_INS_AT) ? (idx_w >= pos_w) : (idx_w + 1'b1 < cnt_w);
		stat.pend       = wv_s1;
		stat.out_free   = out_free;
		stat.dump_last  = (idx_w + 1'b1 == cnt_w);
	end

	// Ring store: a pending entry move has the write port before a new value.
	always_ff @(posedge clk) begin
		if (wv_s1) begin
			mem[wa_s1] <= rdata_q;
		end else if (cmd.wr_val) begin
			mem[vaddr] <= val_q;
		end
		if (cmd.rd_en) begin
			rdata_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= opcode_t'(in_opcode);
			val_q <= val_ext[DATA_WIDTH-1:0];
			pos_q <= in_position;
		end
		if (cmd.st_load) begin
			st_q <= cmd.st;
		end
		if (cmd.mv) begin
			wa_s1 <= slot_of(head_q, idx_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
			idx_q   <= '0;
			wv_s1   <= 1'b0;
		end else begin
			wv_s1 <= cmd.mv;
			case (cmd.head_op)
				HEAD_DEC: head_q <= head_dec;
				HEAD_INC: head_q <= head_inc;
				default:  head_q <= head_q;
			endcase
			case (cmd.cnt_op)
				CNT_INC: count_q <= count_q + 1'b1;
				CNT_DEC: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
			case (cmd.idx_op)
				IDX_LOAD_COUNT: idx_q <= count_q;
				IDX_LOAD_POSM1: idx_q <= CW'(pos_q - POS_W'(1));
				IDX_ZERO:       idx_q <= '0;
				IDX_INC:        idx_q <= idx_p1;
				IDX_DEC:        idx_q <= idx_m1;
				default:        idx_q <= idx_q;
			endcase
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_one || cmd.emit_elem) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_one) begin
			out_status_q <= st_q;
			out_elem_q   <= '0;
			out_count_q  <= cnt_wide[COUNT_W-1:0];
			out_last_q   <= 1'b1;
		end else if (cmd.emit_elem) begin
			out_status_q <= STS_OK;
			out_elem_q   <= rd_ext[ELEM_W-1:0];
			out_count_q  <= cnt_wide[COUNT_W-1:0];
			out_last_q   <= stat.dump_last;
		end
	end

	assign m_tvalid  = out_valid_q;
	assign m_status  = out_status_q;
	assign m_element = out_elem_q;
	assign m_count   = out_count_q;
	assign m_last    = out_last_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("element count exceeds capacity");

	a_write_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(wv_s1 && cmd.wr_val))
		else $error("entry move and value write collide on the write port");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (count_q == $past(count_q)) || (count_q == $past(count_q) + 1'b1)
			|| ($past(count_q) == count_q + 1'b1))
		else $error("element count moved by more than one");

endmodule

>>> rtl/positional_circular_list.sv
// ----------------------------------------------------------------------------
// positional_circular_list
// Positional circular list: an ordered list of up to CAPACITY signed words held in a
// ring store, taking one operation per input transaction (insert or delete at front,
// back or a 1-based position, or dump in order). Operations run one at a time; the
// next transaction is taken in the cycle after the previous result is loaded, while
// that result may still wait on the output. Front and back operations and all errors
// go from decode to the emit state, which loads the result once the output is free.
// Positional insert moves count-pos+1 entries and positional delete count-pos, one
// entry move per cycle through the store's single read and write port, then drains
// the last write and finishes. A dump reads its first element after decode and then
// loads one result per element per cycle while the output is taken. The store needs
// no clearing after reset.
// ----------------------------------------------------------------------------
module positional_circular_list #(
	parameter int CAPACITY   = pcl_pkg::DEF_CAPACITY,
	parameter int DATA_WIDTH = pcl_pkg::DEF_DATA_WIDTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// opcode[2:0], value[34:3], position[42:35], zero fill above
	input  logic [pcl_pkg::S_TDATA_W-1:0]  s_tdata,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// element[31:0], element_count[36:32], zero fill above
	output logic [pcl_pkg::M_TDATA_W-1:0]  m_tdata,
	// status[1:0]
	output logic [pcl_pkg::M_TUSER_W-1:0]  m_tuser,
	output logic                           m_tlast
);
	import pcl_pkg::*;

	localparam int VAL_LO = OPCODE_W;
	localparam int POS_LO = OPCODE_W + VALUE_W;

	pcl_cmd_t             cmd;
	pcl_stat_t            stat;
	status_t              m_status;
	logic [ELEM_W-1:0]    m_element;
	logic [COUNT_W-1:0]   m_count;

	pcl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	pcl_dp #(
		.CAPACITY   (CAPACITY),
		.DATA_WIDTH (DATA_WIDTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_opcode   (s_tdata[OPCODE_W-1:0]),
		.in_value    (s_tdata[VAL_LO +: VALUE_W]),
		.in_position (s_tdata[POS_LO +: POS_W]),
		.cmd         (cmd),
		.stat        (stat),
		.m_tready    (m_tready),
		.m_tvalid    (m_tvalid),
		.m_status    (m_status),
		.m_element   (m_element),
		.m_count     (m_count),
		.m_last      (m_tlast)
	);

	assign m_tdata = M_TDATA_W'({m_count, m_element});
	assign m_tuser = m_status;

endmodule

>>> bench/positional_circular_list_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// positional_circular_list_tb
// Self-checking bench for the positional circular list. A shadow list in a
// scoreboard class predicts every result transaction from the accepted input
// transactions. A directed pass covers the error cases and the list limits,
// and a steered random pass then walks the list between empty and full under
// random input bursts and output stalls.
// ----------------------------------------------------------------------------
module positional_circular_list_tb;
	import pcl_pkg::*;

	localparam int CAPACITY = DEF_CAPACITY;
	localparam logic [OPCODE_W-1:0] OP_UNUSED = 3'd7;
	localparam int HOLD_CYCLES   = 300;
	localparam int RANDOM_ITEMS  = 70;
	localparam int SETTLE_CYCLES = 40;
	localparam int MAX_REPORTS   = 20;

	typedef struct {
		status_t            status;
		logic [ELEM_W-1:0]  element;
		logic [COUNT_W-1:0] count;
		logic               last;
	} list_result_t;

	class list_shadow;
		logic [VALUE_W-1:0] entries[$];
		list_result_t       pending_results[$];
		int errors, results_seen, ops_seen, full_seen, empty_seen;

		function void post(status_t st, logic [ELEM_W-1:0] elem, logic last);
			list_result_t r;
			r.status  = st;
			r.element = elem;
			r.count   = COUNT_W'(entries.size());
			r.last    = last;
			pending_results.push_back(r);
			if (st == STS_FULL) full_seen++;
			if (st == STS_EMPTY) empty_seen++;
		endfunction

		// Applies one accepted operation to the shadow list and queues its results.
		function void note_op(logic [S_TDATA_W-1:0] word);
			logic [OPCODE_W-1:0] op;
			logic [VALUE_W-1:0]  value;
			int                  pos;
			int                  n;
			status_t             st;
			op    = word[OPCODE_W-1:0];
			value = word[OPCODE_W +: VALUE_W];
			pos   = int'(word[OPCODE_W+VALUE_W +: POS_W]);
			n     = entries.size();
			st    = STS_OK;
			ops_seen++;
			case (op)
				OP_INS_FRONT: if (n >= CAPACITY) st = STS_FULL; else entries.push_front(value);
				OP_INS_BACK:  if (n >= CAPACITY) st = STS_FULL; else entries.push_back(value);
				OP_DEL_FRONT: if (n == 0) st = STS_EMPTY; else void'(entries.pop_front());
				OP_DEL_BACK:  if (n == 0) st = STS_EMPTY; else void'(entries.pop_back());
				OP_INS_AT: begin
					// The position is checked before fullness.
					if (pos < 1 || pos > n + 1) st = STS_BADPOS;
					else if (n >= CAPACITY) st = STS_FULL;
					else entries.insert(pos - 1, value);
				end
				OP_DEL_AT: begin
					if (n == 0) st = STS_EMPTY;
					else if (pos < 1 || pos > n) st = STS_BADPOS;
					else entries.delete(pos - 1);
				end
				OP_DUMP: begin
					if (n == 0) begin
						st = STS_EMPTY;
					end else begin
						for (int i = 0; i < n; i++)
							post(STS_OK, entries[i], i == n - 1);
						return;
					end
				end
				default: ;
			endcase
			post(st, '0, 1'b1);
		endfunction

		function void mismatch(string field, logic [31:0] want_v, logic [31:0] got_v);
			errors++;
			if (errors <= MAX_REPORTS)
				$display("%0t: %s mismatch, expected 0x%0h, got 0x%0h",
					$time, field, want_v, got_v);
		endfunction

		function void check_result(logic [M_TDATA_W-1:0] data, logic [M_TUSER_W-1:0] user,
				logic last);
			list_result_t want;
			results_seen++;
			if (pending_results.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: result transaction with none expected, got element 0x%0h",
						$time, data[ELEM_W-1:0]);
				return;
			end
			want = pending_results.pop_front();
			if (user !== want.status) mismatch("status", 32'(want.status), 32'(user));
			if (data[ELEM_W-1:0] !== want.element)
				mismatch("element", want.element, data[ELEM_W-1:0]);
			if (data[ELEM_W +: COUNT_W] !== want.count)
				mismatch("element_count", 32'(want.count), 32'(data[ELEM_W +: COUNT_W]));
			if (last !== want.last) mismatch("last", 32'(want.last), 32'(last));
		endfunction
	endclass

	logic                 clk      = 1'b0;
	logic                 arst_n   = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic [S_TDATA_W-1:0] s_tdata  = '0;
	logic                 m_tready = 1'b0;
	logic                 s_tready;
	logic                 m_tvalid;
	logic [M_TDATA_W-1:0] m_tdata;
	logic [M_TUSER_W-1:0] m_tuser;
	logic                 m_tlast;

	bit         hold_request = 1'b0;
	bit         hold_active  = 1'b0;
	bit         filling      = 1'b1;
	int         burst_left   = 0;
	list_shadow sb;

	positional_circular_list i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Inputs are noted before outputs are checked, both on the same edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) sb.note_op(s_tdata);
			if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser, m_tlast);
		end
	end

	// Output side: runs of always-ready, random, mostly-stalled and toggling ready,
	// and one long hold-off on request.
	initial begin : receiver
		int mode;
		int run;
		bit toggle;
		toggle = 1'b0;
		forever begin
			if (hold_request) begin
				hold_active = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_active  = 1'b0;
				hold_request = 1'b0;
			end else begin
				mode = $urandom_range(0, 3);
				run  = $urandom_range(4, 40);
				repeat (run) begin
					toggle = !toggle;
					case (mode)
						0: m_tready <= 1'b1;
						1: m_tready <= 1'($urandom_range(0, 1));
						2: m_tready <= ($urandom_range(0, 3) == 0);
						default: m_tready <= toggle;
					endcase
					@(posedge clk);
				end
			end
		end
	end

	task automatic send_op(logic [OPCODE_W-1:0] op, logic [VALUE_W-1:0] value,
			logic [POS_W-1:0] pos);
		s_tvalid <= 1'b1;
		s_tdata  <= {{(S_TDATA_W - OPCODE_W - VALUE_W - POS_W){1'b0}}, pos, value, op};
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic pause(int cycles);
		s_tvalid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// Sends in bursts of random length; most bursts are preceded by a gap.
	task automatic offer(logic [OPCODE_W-1:0] op, logic [VALUE_W-1:0] value,
			logic [POS_W-1:0] pos);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			if ($urandom_range(0, 3) != 0) pause($urandom_range(1, 6));
		end
		burst_left--;
		send_op(op, value, pos);
	endtask

	task automatic wait_for_drain();
		s_tvalid  <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (sb.pending_results.size() != 0);
	endtask

	// Steers the list between empty and full; most positions are in range.
	task automatic random_item();
		int                  n;
		int                  r;
		bit                  grow;
		logic [OPCODE_W-1:0] op;
		logic [VALUE_W-1:0]  value;
		logic [POS_W-1:0]    pos;
		n = sb.entries.size();
		if (n >= CAPACITY) filling = 1'b0;
		else if (n == 0) filling = 1'b1;
		else if ($urandom_range(0, 29) == 0) filling = !filling;
		grow = filling ? ($urandom_range(0, 9) < 7) : ($urandom_range(0, 9) < 3);
		r = $urandom_range(0, 99);
		if (r < 8) begin
			op = OP_DUMP;
		end else if (r < 10) begin
			op = OP_UNUSED;
		end else begin
			case ($urandom_range(0, 2))
				0: op = grow ? OP_INS_FRONT : OP_DEL_FRONT;
				1: op = grow ? OP_INS_BACK : OP_DEL_BACK;
				default: op = grow ? OP_INS_AT : OP_DEL_AT;
			endcase
		end
		case ($urandom_range(0, 19))
			0: value = 32'h8000_0000;
			1: value = 32'h7fff_ffff;
			2: value = 32'hffff_ffff;
			3: value = 32'h0000_0000;
			default: value = $urandom;
		endcase
		if ($urandom_range(0, 6) == 0) pos = POS_W'($urandom_range(0, 255));
		else if (op == OP_DEL_AT) pos = (n == 0) ? POS_W'(1) : POS_W'($urandom_range(1, n));
		else pos = POS_W'($urandom_range(1, n + 1));
		offer(op, value, pos);
	endtask

	initial begin
		#2_000_000;
		$display("Verification failed");
		$finish;
	end

	initial begin
		sb = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty list: dump, every delete, bad insert positions, unused opcode.
		offer(OP_DUMP, '0, '0);
		offer(OP_DEL_FRONT, '0, '0);
		offer(OP_DEL_BACK, '0, '0);
		offer(OP_DEL_AT, '0, 8'd1);
		offer(OP_INS_AT, 32'h1234_5678, 8'd0);
		offer(OP_INS_AT, 32'h1234_5678, 8'd2);
		offer(OP_UNUSED, 32'hffff_ffff, 8'hff);
		// Insert into an empty list, then delete the only element.
		offer(OP_INS_AT, 32'h0000_0001, 8'd1);
		offer(OP_DEL_AT, '0, 8'd1);
		offer(OP_INS_FRONT, 32'h8000_0000, '0);
		offer(OP_INS_BACK, 32'h7fff_ffff, '0);
		offer(OP_INS_AT, 32'h0000_0000, 8'd3);
		offer(OP_INS_AT, 32'h5555_5555, 8'd2);
		offer(OP_INS_AT, 32'hffff_ffff, 8'd1);
		offer(OP_DUMP, '0, '0);
		offer(OP_DEL_AT, '0, 8'd0);
		offer(OP_DEL_AT, '0, 8'd6);
		offer(OP_DEL_AT, '0, 8'hff);
		offer(OP_INS_AT, 32'haaaa_aaaa, 8'd7);
		offer(OP_INS_AT, 32'haaaa_aaaa, 8'hff);
		offer(OP_DEL_AT, '0, 8'd5);
		offer(OP_DEL_AT, '0, 8'd2);
		offer(OP_DEL_FRONT, '0, '0);
		offer(OP_DUMP, '0, '0);
		offer(OP_DEL_BACK, '0, '0);
		wait_for_drain();

		// Fill to capacity, then hit every insert on a full list.
		repeat (CAPACITY - sb.entries.size()) offer(OP_INS_BACK, $urandom, '0);
		offer(OP_INS_FRONT, 32'h0bad_0bad, '0);
		offer(OP_INS_BACK, 32'h0bad_0bad, '0);
		offer(OP_INS_AT, 32'h0bad_0bad, POS_W'(CAPACITY + 1));
		offer(OP_INS_AT, 32'h0bad_0bad, POS_W'(CAPACITY + 2));
		offer(OP_INS_AT, 32'h0bad_0bad, 8'd0);
		offer(OP_DUMP, '0, '0);
		offer(OP_DEL_AT, '0, POS_W'(CAPACITY));
		offer(OP_DEL_AT, '0, 8'd1);
		offer(OP_INS_AT, 32'hc0de_c0de, 8'd8);
		offer(OP_INS_FRONT, 32'h8000_0000, '0);
		offer(OP_DUMP, '0, '0);
		wait_for_drain();

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == 20) begin
				// Keep offering while the output is held off so the input backs up.
				hold_request = 1'b1;
				s_tvalid    <= 1'b0;
				burst_left   = 0;
				do @(posedge clk); while (!hold_active);
			end
			if (i == 45) wait_for_drain();
			random_item();
		end
		wait_for_drain();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Ran %0d operations, checked %0d result transactions.",
			sb.ops_seen, sb.results_seen);
		$display("Full-list answers: %0d, empty-list answers: %0d, mismatches: %0d.",
			sb.full_seen, sb.empty_seen, sb.errors);
		if (sb.errors == 0 && sb.pending_results.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule

>>> sim.f
rtl/pcl_pkg.sv
rtl/pcl_ctrl.sv
rtl/pcl_dp.sv
rtl/positional_circular_list.sv
bench/positional_circular_list_tb.sv
